// ===== src/sbm_pkg.sv =====
`default_nettype none
package sbm_pkg;

    localparam int LINE_W     = 256;
    localparam int ADDR_W     = 8;
    localparam int PIX_W      = 8;
    localparam int SHIFTS     = 16;
    localparam int SHIFT_W    = 4;
    localparam int RAD        = 4;
    localparam int WIN        = 2 * RAD + 1;
    localparam int LINE_ROWS  = 16;
    localparam int BANK_W     = 4;
    localparam int SRCH_COLS  = WIN + SHIFTS - 1;
    localparam int SIDX_W     = 5;
    localparam int LANE_W     = 12;
    localparam int COST_W     = 15;
    localparam int CFG_W      = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int POS_W      = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 2'd2;

    localparam logic [CFG_W-1:0] WIDTH_RST  = 9'd160;
    localparam logic [CFG_W-1:0] HEIGHT_RST = 9'd120;
    localparam logic [2:0]       OFFSET_RST = 3'd7;

    typedef logic [PIX_W-1:0] pix_t;

    // one shift candidate moving down the sad pipeline
    typedef struct packed {
        logic               vld;
        logic               first;
        logic               last;
        logic [SHIFT_W-1:0] shift;
    } sbm_stage_t;

    // shift * 255 / 16, truncated
    function automatic logic [7:0] sbm_disp_code(input logic [SHIFT_W-1:0] d);
        logic [11:0] p;
        p = {d, 8'd0} - 12'(d);
        return p[11:4];
    endfunction

endpackage
`default_nettype wire

// ===== src/sbm_ram.sv =====
`default_nettype none
module sbm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ===== src/sbm_lane.sv =====
`default_nettype none
module sbm_lane (
    input  wire logic                                    clk,
    input  wire sbm_pkg::pix_t [sbm_pkg::WIN-1:0]        ref_px,
    input  wire sbm_pkg::pix_t [sbm_pkg::SRCH_COLS-1:0]  srch_px,
    input  wire logic [sbm_pkg::SHIFT_W-1:0]             shift,
    output logic [sbm_pkg::LANE_W-1:0]                   sum
);
    import sbm_pkg::*;

    logic [LANE_W-1:0] acc;
    logic [LANE_W-1:0] sum_reg;

    // one window row: ref column j against search column j shifted left by shift
    always_comb
    begin
        logic [SIDX_W-1:0] idx;
        pix_t              a;
        pix_t              b;
        acc = '0;
        for (int j = 0; j < WIN; j++)
        begin
            idx = SIDX_W'(WIN - 1 - j) + SIDX_W'(shift);
            a   = ref_px[j];
            b   = srch_px[idx];
            acc = acc + LANE_W'((a > b) ? (a - b) : (b - a));
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= acc;
    end

    assign sum = sum_reg;

endmodule
`default_nettype wire

// ===== src/sbm_merge.sv =====
`default_nettype none
module sbm_merge (
    input  wire logic                                      clk,
    input  wire logic                                      rst_n,
    input  wire sbm_pkg::sbm_stage_t                       stage,
    input  wire logic [sbm_pkg::WIN-1:0][sbm_pkg::LANE_W-1:0] lane_sum,
    output logic                                           done,
    output logic [sbm_pkg::SHIFT_W-1:0]                    best_shift,
    output logic [sbm_pkg::COST_W-1:0]                     match_cost
);
    import sbm_pkg::*;

    logic [COST_W-1:0]  total;
    logic [COST_W-1:0]  match_cost_reg;
    logic [SHIFT_W-1:0] best_shift_reg;
    logic               done_reg;

    always_comb
    begin
        total = '0;
        for (int i = 0; i < WIN; i++)
        begin
            total = total + COST_W'(lane_sum[i]);
        end
    end

    // strict less keeps the smallest shift on ties
    always_ff @(posedge clk)
    begin
        if (stage.vld && (stage.first || total < match_cost_reg))
        begin
            match_cost_reg <= total;
            best_shift_reg <= stage.shift;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else if (stage.vld && stage.last)
        begin
            done_reg <= 1'b1;
        end
        else if (stage.vld && stage.first)
        begin
            done_reg <= 1'b0;
        end
    end

    assign done       = done_reg;
    assign best_shift = best_shift_reg;
    assign match_cost = match_cost_reg;

endmodule
`default_nettype wire

// ===== src/stereo_sad_block_match_disparity.sv =====
`default_nettype none
// channel   | dir | handshake                   | payload
// s_axis    | in  | s_axis_tvalid/s_axis_tready | ref_pixel, search_pixel
// m_axis    | out | m_axis_tvalid/m_axis_tready | column, row, code, shift, cost
// cfg       | in  | cfg_we                      | cfg_index, cfg_wdata
//
// a beat with no result due returns to idle after the bank read; any other beat reads
// the sixteen row banks, then sends one shift candidate per cycle through nine row
// lanes and waits for the lane sums and the merging compare to drain and a free output.
// rst_n clears counters and control, resets config; line banks hold garbage until written.
// a finished result sits in the output register while the next beat is taken;
// a stalled output only blocks once the following result is ready.
module stereo_sad_block_match_disparity (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [15:0]                     s_axis_tdata,  // ref_pixel, search_pixel
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // out_column, out_row, disparity_code, best_shift, match_cost, zero fill
    output logic [47:0]                          m_axis_tdata,
    input  wire logic                            cfg_we,
    input  wire logic [sbm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [sbm_pkg::CFG_W-1:0]       cfg_wdata
);
    import sbm_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_CALC = 2'd2;
    localparam logic [1:0] ST_WAIT = 2'd3;

    logic [1:0]         state_reg, state_next;
    logic [CFG_W-1:0]   width_reg, height_reg;
    logic [2:0]         offset_reg;
    logic [POS_W-1:0]   col_reg, col_next;
    logic [POS_W-1:0]   row_reg, row_next;

    logic [CFG_W-1:0]   eff_w, eff_h;
    logic               accept;
    logic [CFG_W-1:0]   col_ext, c0, r_tmp, r0, c1, r1;
    logic               emit;

    pix_t               cur_ref_reg, cur_srch_reg;
    logic [BANK_W-1:0]  cur_bank_reg, ref_base_reg, srch_base_reg;
    logic               emit_reg;
    logic [POS_W-1:0]   x_reg, y_reg;

    pix_t [LINE_ROWS-1:0] ref_rd, srch_rd;
    pix_t [WIN-1:0]       new_ref_col, new_srch_col;
    pix_t [WIN-1:0][WIN-1:0]       ref_win_reg;   // [column age][row]
    pix_t [SRCH_COLS-1:0][WIN-1:0] srch_win_reg;

    logic [SHIFT_W-1:0]   d_reg;
    sbm_stage_t           issue, stage_reg;
    logic [WIN-1:0][LANE_W-1:0] lane_sum;

    logic               merge_done;
    logic [SHIFT_W-1:0] merge_shift;
    logic [COST_W-1:0]  merge_cost;
    logic               load;

    logic               out_valid_reg;
    logic [POS_W-1:0]   out_col_reg, out_row_reg;
    logic [7:0]         out_code_reg;
    logic [SHIFT_W-1:0] out_shift_reg;
    logic [COST_W-1:0]  out_cost_reg;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
            offset_reg <= OFFSET_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_WIDTH:  width_reg  <= cfg_wdata;
                CFG_HEIGHT: height_reg <= cfg_wdata;
                CFG_OFFSET: offset_reg <= cfg_wdata[2:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        eff_w = (width_reg == '0) ? CFG_W'(1) :
                (width_reg > CFG_W'(LINE_W)) ? CFG_W'(LINE_W) : width_reg;
        eff_h = (height_reg == '0) ? CFG_W'(1) :
                (height_reg > CFG_W'(256)) ? CFG_W'(256) : height_reg;
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    // position of this beat; counters wrap early if geometry shrank
    always_comb
    begin
        col_ext = {1'b0, col_reg};
        c0      = (col_ext >= eff_w) ? '0 : col_ext;
        r_tmp   = (col_ext >= eff_w) ? {1'b0, row_reg} + CFG_W'(1) : {1'b0, row_reg};
        r0      = (r_tmp >= eff_h) ? '0 : r_tmp;
        c1      = c0 + CFG_W'(1);
        r1      = r0 + CFG_W'(1);
        if (c1 >= eff_w)
        begin
            col_next = '0;
            row_next = (r1 >= eff_h) ? '0 : r1[POS_W-1:0];
        end
        else
        begin
            col_next = c1[POS_W-1:0];
            row_next = r0[POS_W-1:0];
        end
        emit = (c0 >= CFG_W'(2 * RAD + SHIFTS)) &&
               (r0 >= CFG_W'(2 * RAD) + CFG_W'(offset_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cur_ref_reg   <= s_axis_tdata[7:0];
            cur_srch_reg  <= s_axis_tdata[15:8];
            cur_bank_reg  <= r0[BANK_W-1:0];
            ref_base_reg  <= r0[BANK_W-1:0] - BANK_W'(2 * RAD);
            srch_base_reg <= r0[BANK_W-1:0] - BANK_W'(2 * RAD) - BANK_W'(offset_reg);
            x_reg         <= c0[POS_W-1:0] - POS_W'(RAD);
            y_reg         <= r0[POS_W-1:0] - POS_W'(RAD) - POS_W'(offset_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            emit_reg <= 1'b0;
        end
        else if (accept)
        begin
            emit_reg <= emit;
        end
    end

    // one bank per line, modulo sixteen lines
    for (genvar b = 0; b < LINE_ROWS; b++)
    begin : g_bank
        logic bank_we;
        assign bank_we = accept && (r0[BANK_W-1:0] == BANK_W'(b));

        sbm_ram #(.WIDTH(PIX_W), .DEPTH(LINE_W)) u_ref_ram (
            .clk   (clk),
            .we    (bank_we),
            .waddr (c0[ADDR_W-1:0]),
            .wdata (s_axis_tdata[7:0]),
            .raddr (c0[ADDR_W-1:0]),
            .rdata (ref_rd[b])
        );

        sbm_ram #(.WIDTH(PIX_W), .DEPTH(LINE_W)) u_srch_ram (
            .clk   (clk),
            .we    (bank_we),
            .waddr (c0[ADDR_W-1:0]),
            .wdata (s_axis_tdata[15:8]),
            .raddr (c0[ADDR_W-1:0]),
            .rdata (srch_rd[b])
        );
    end

    // the current line comes from the beat itself, not the bank
    always_comb
    begin
        logic [BANK_W-1:0] rb;
        logic [BANK_W-1:0] sb;
        for (int i = 0; i < WIN; i++)
        begin
            rb = ref_base_reg + BANK_W'(i);
            sb = srch_base_reg + BANK_W'(i);
            new_ref_col[i]  = (rb == cur_bank_reg) ? cur_ref_reg  : ref_rd[rb];
            new_srch_col[i] = (sb == cur_bank_reg) ? cur_srch_reg : srch_rd[sb];
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_READ)
        begin
            ref_win_reg[0]  <= new_ref_col;
            srch_win_reg[0] <= new_srch_col;
            for (int k = 1; k < WIN; k++)
            begin
                ref_win_reg[k] <= ref_win_reg[k-1];
            end
            for (int k = 1; k < SRCH_COLS; k++)
            begin
                srch_win_reg[k] <= srch_win_reg[k-1];
            end
        end
    end

    // sequencer
    always_comb
    begin
        load       = (state_reg == ST_WAIT) && merge_done && (!out_valid_reg || m_axis_tready);
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (accept) state_next = ST_READ;
            ST_READ: state_next = emit_reg ? ST_CALC : ST_IDLE;
            ST_CALC: if (d_reg == SHIFT_W'(SHIFTS - 1)) state_next = ST_WAIT;
            ST_WAIT: if (load) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
        issue.vld   = (state_reg == ST_CALC);
        issue.first = (d_reg == '0);
        issue.last  = (d_reg == SHIFT_W'(SHIFTS - 1));
        issue.shift = d_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            d_reg     <= '0;
            stage_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            stage_reg <= issue;
            d_reg     <= (state_reg == ST_CALC) ? d_reg + SHIFT_W'(1) : '0;
        end
    end

    for (genvar i = 0; i < WIN; i++)
    begin : g_lane
        pix_t [WIN-1:0]       lane_ref;
        pix_t [SRCH_COLS-1:0] lane_srch;

        for (genvar j = 0; j < WIN; j++)
        begin : g_ref
            assign lane_ref[j] = ref_win_reg[WIN-1-j][i];
        end
        for (genvar k = 0; k < SRCH_COLS; k++)
        begin : g_srch
            assign lane_srch[k] = srch_win_reg[k][i];
        end

        sbm_lane u_lane (
            .clk     (clk),
            .ref_px  (lane_ref),
            .srch_px (lane_srch),
            .shift   (d_reg),
            .sum     (lane_sum[i])
        );
    end

    sbm_merge u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .stage      (stage_reg),
        .lane_sum   (lane_sum),
        .done       (merge_done),
        .best_shift (merge_shift),
        .match_cost (merge_cost)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_col_reg   <= x_reg;
            out_row_reg   <= y_reg;
            out_code_reg  <= sbm_disp_code(merge_shift);
            out_shift_reg <= merge_shift;
            out_cost_reg  <= merge_cost;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, out_cost_reg, out_shift_reg, out_code_reg,
                            out_row_reg, out_col_reg};

    a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_READ)
        else $error("accepted beat did not go to bank read");

    a_rise_from_wait: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_WAIT)
        else $error("result appeared without finished search");

    a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
        stage_reg.vld && stage_reg.last |=> merge_done)
        else $error("merge did not finish after last shift");

    a_code_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> m_axis_tdata[23:16] == sbm_disp_code(m_axis_tdata[27:24]))
        else $error("disparity code does not follow best shift");

endmodule
`default_nettype wire

// ===== sim/tb.sv =====
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import sbm_pkg::*;

    typedef struct {
        logic [7:0]  column;
        logic [7:0]  row;
        logic [7:0]  code;
        logic [3:0]  shift;
        logic [14:0] cost;
    } disparity_t;

    localparam int PAT_RANDOM = 0;
    localparam int PAT_SHIFTED = 1;
    localparam int PAT_ZERO = 2;
    localparam int PAT_FULL = 3;
    localparam int PAT_OPPOSITE = 4;

    // index with no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;   // ref_pixel, search_pixel
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;   // out_column, out_row, disparity_code, best_shift, match_cost
    logic        cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;

    stereo_sad_block_match_disparity i_dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    // shadow of the block
    logic [8:0] sh_width;
    logic [8:0] sh_height;
    logic [2:0] sh_offset;
    int         col_pos;
    int         row_pos;
    logic [7:0] ref_lines [16][256];
    logic [7:0] srch_lines [16][256];

    disparity_t disparity_q[$];
    int error_count;
    int beats_sent;
    bit tx_steady;
    bit rx_steady;
    int rx_hold_request;

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    initial
    begin
        #20ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    function automatic int clamp_dim(input logic [8:0] v);
        if (v < 1)
            return 1;
        if (v > 256)
            return 256;
        return v;
    endfunction

    function automatic void predict_disparity(input logic [7:0] rp, input logic [7:0] sp);
        int ew;
        int eh;
        int off;
        int c;
        int r;
        int x;
        int y;
        int sum;
        int best;
        int best_d;
        int a;
        int b;
        disparity_t res;
        ew = clamp_dim(sh_width);
        eh = clamp_dim(sh_height);
        off = sh_offset;
        if (col_pos >= ew)
        begin
            col_pos = 0;
            row_pos++;
        end
        if (row_pos >= eh)
            row_pos = 0;
        c = col_pos;
        r = row_pos;
        ref_lines[r % 16][c] = rp;
        srch_lines[r % 16][c] = sp;
        if (c >= 2 * RAD + SHIFTS && r >= 2 * RAD + off)
        begin
            x = c - RAD;
            y = r - RAD - off;
            best = 0;
            best_d = 0;
            for (int d = 0; d < SHIFTS; d++)
            begin
                sum = 0;
                for (int i = 0; i < WIN; i++)
                    for (int j = 0; j < WIN; j++)
                    begin
                        a = ref_lines[(y + off + i - RAD) % 16][x + j - RAD];
                        b = srch_lines[(y + i - RAD) % 16][x - d + j - RAD];
                        sum += (a > b) ? a - b : b - a;
                    end
                if (d == 0 || sum < best)
                begin
                    best = sum;
                    best_d = d;
                end
            end
            if (best > 32767)
                best = 32767;
            res.column = x[7:0];
            res.row = y[7:0];
            res.code = 8'((best_d * 255) / SHIFTS);
            res.shift = best_d[3:0];
            res.cost = best[14:0];
            disparity_q.push_back(res);
        end
        col_pos = c + 1;
        if (col_pos >= ew)
        begin
            col_pos = 0;
            row_pos = r + 1;
            if (row_pos >= eh)
                row_pos = 0;
        end
    endfunction

    // input and register monitor
    always @(posedge clk)
    begin
        if (rst_n && cfg_we)
        begin
            case (cfg_index)
                CFG_WIDTH: sh_width = cfg_wdata;
                CFG_HEIGHT: sh_height = cfg_wdata;
                CFG_OFFSET: sh_offset = cfg_wdata[2:0];
                default: ;
            endcase
        end
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            predict_disparity(s_axis_tdata[7:0], s_axis_tdata[15:8]);
            beats_sent++;
        end
    end

    // result checker
    always @(posedge clk)
    begin
        disparity_t e;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (disparity_q.size() == 0)
                report_mismatch($sformatf("unexpected beat %h", m_axis_tdata));
            else
            begin
                e = disparity_q.pop_front();
                if (m_axis_tdata[7:0] !== e.column)
                    report_mismatch($sformatf("column %0d, want %0d", m_axis_tdata[7:0], e.column));
                if (m_axis_tdata[15:8] !== e.row)
                    report_mismatch($sformatf("row %0d, want %0d", m_axis_tdata[15:8], e.row));
                if (m_axis_tdata[23:16] !== e.code)
                    report_mismatch($sformatf("code %0d, want %0d", m_axis_tdata[23:16], e.code));
                if (m_axis_tdata[27:24] !== e.shift)
                    report_mismatch($sformatf("shift %0d, want %0d", m_axis_tdata[27:24], e.shift));
                if (m_axis_tdata[42:28] !== e.cost)
                    report_mismatch($sformatf("cost %0d, want %0d", m_axis_tdata[42:28], e.cost));
                if (m_axis_tdata[47:43] !== 5'd0)
                    report_mismatch("fill bits not zero");
            end
        end
    end

    function automatic int pick_gap(input bit steady);
        int p;
        p = $urandom_range(0, 99);
        if (steady || p < 60)
            return 0;
        if (p < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // receiver stalls
    always @(negedge clk)
    begin
        static int stall = 0;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (rx_hold_request > 0)
        begin
            stall = rx_hold_request - 1;
            rx_hold_request = 0;
            m_axis_tready <= 1'b0;
        end
        else if (stall > 0)
        begin
            stall--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            stall = pick_gap(rx_steady);
            m_axis_tready <= (stall == 0);
        end
    end

    task automatic send_pixels(input logic [7:0] rp, input logic [7:0] sp);
        int gap;
        gap = pick_gap(tx_steady);
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {sp, rp};
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic drain_results();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        wait (disparity_q.size() == 0);
        // a beat without a result can still be in flight
        repeat (40) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [7:0] texture(input int u, input int v);
        logic [31:0] h;
        h = 32'(u * 37 + v * 101 + 7) * 32'h9E3779B1;
        return h[23:16];
    endfunction

    // one whole frame, so every window reads rows written in this frame
    task automatic run_frame(input logic [8:0] w, input logic [8:0] h, input logic [2:0] off,
                             input int pattern, input int hold_at);
        int ew;
        int eh;
        int dd;
        int n;
        logic [7:0] rp;
        logic [7:0] sp;
        drain_results();
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
        write_reg(CFG_OFFSET, {6'd0, off});
        ew = clamp_dim(w);
        eh = clamp_dim(h);
        dd = $urandom_range(0, SHIFTS - 1);
        n = 0;
        for (int r = 0; r < eh; r++)
            for (int c = 0; c < ew; c++)
            begin
                case (pattern)
                    PAT_SHIFTED:
                    begin
                        rp = texture(c, r - off);
                        sp = texture(c + dd, r);
                        if ($urandom_range(0, 15) == 0)
                            sp = 8'($urandom);
                    end
                    PAT_ZERO:
                    begin
                        rp = 8'd0;
                        sp = 8'd0;
                    end
                    PAT_FULL:
                    begin
                        rp = 8'hFF;
                        sp = 8'hFF;
                    end
                    PAT_OPPOSITE:
                    begin
                        rp = 8'hFF;
                        sp = 8'd0;
                    end
                    default:
                    begin
                        rp = 8'($urandom);
                        sp = 8'($urandom);
                    end
                endcase
                if (n == hold_at)
                    rx_hold_request = 3000;
                send_pixels(rp, sp);
                n++;
            end
    endtask

    task automatic test_directed();
        run_frame(9'd0, 9'd0, 3'd0, PAT_RANDOM, -1);
        write_reg(CFG_SPARE, 9'h1FF);
        run_frame(9'd25, 9'd9, 3'd0, PAT_OPPOSITE, -1);
        run_frame(9'd26, 9'd10, 3'd1, PAT_FULL, -1);
    endtask

    task automatic test_random_frames();
        int off;
        while (beats_sent < 1150)
        begin
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);
            off = $urandom_range(0, 7);
            run_frame(9'($urandom_range(25, 28)), 9'(2 * RAD + 1 + off + $urandom_range(0, 2)),
                      3'(off),
                      ($urandom_range(0, 3) == 0) ? PAT_RANDOM : PAT_SHIFTED, -1);
        end
        tx_steady = 0;
        rx_steady = 0;
    endtask

    task automatic test_backpressure();
        tx_steady = 1;
        run_frame(9'd28, 9'd17, 3'd2, PAT_SHIFTED, 250);
        tx_steady = 0;
        // sender pauses until everything is out
        drain_results();
    endtask

    task automatic test_large_geometry();
        run_frame(9'd300, 9'd1, 3'd0, PAT_ZERO, -1);
        run_frame(9'd1, 9'd511, 3'd0, PAT_RANDOM, -1);
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        sh_width = WIDTH_RST;
        sh_height = HEIGHT_RST;
        sh_offset = OFFSET_RST;
        col_pos = 0;
        row_pos = 0;
        error_count = 0;
        beats_sent = 0;
        tx_steady = 0;
        rx_steady = 0;
        rx_hold_request = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_backpressure();
        test_random_frames();
        test_large_geometry();
        drain_results();
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
`default_nettype wire
